>>> hw/rtl/stream_search_replace_assert.svh
// stream_search_replace_assert.svh: assertion macros for the search and replace block
// depends on nothing; included by the modules that carry assertions
`ifndef STREAM_SEARCH_REPLACE_ASSERT_SVH
`define STREAM_SEARCH_REPLACE_ASSERT_SVH

// assertion on an explicit clock and active-low reset
`define SSR_ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// assertion on the block clock and reset
`define SSR_ASSERT(lbl, prop, msg) \
  `SSR_ASSERT_AT(lbl, clk_i, rst_ni, prop, msg)

`endif

>>> hw/rtl/ssr_pkg.sv
// ssr_pkg: shared types and constants of the stream search and replace block
// no dependencies; used by ssr_ctrl, ssr_dp and stream_search_replace
package ssr_pkg;

  localparam int BYTE_W          = 8;
  localparam int NUM_REPL        = 8;   // replacement bytes held in the config
  localparam int CNT_W           = 4;   // holds a word count up to 8
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 64;
  localparam int LEN_W           = 4;
  localparam int MAX_PATTERN_DEF = 8;

  localparam logic [BYTE_W-1:0] NEWLINE = 8'd10;

  // input command codes
  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_EOL  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_BYTES = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LEN   = 2'd3;

  typedef struct packed {
    logic              cmd;
    logic [BYTE_W-1:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last_of_run;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic take;   // accept the input word this cycle
    logic emit;   // move the next burst byte into the output register
    logic last;   // that byte is the final one of the burst
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [CNT_W-1:0] burst_cnt;  // results the presented word would cause
  } dp_stat_t;

endpackage

>>> hw/rtl/ssr_dp.sv
// ssr_dp: datapath of the search and replace block: config registers, match
// window, pattern compare, burst buffer and output register; uses ssr_pkg
module ssr_dp #(
  parameter int MaxPattern = ssr_pkg::MAX_PATTERN_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ssr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ssr_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  ssr_pkg::in_item_t                in_i,
  input  ssr_pkg::ctrl_cmd_t               cmd_i,
  output ssr_pkg::dp_stat_t                stat_o,
  output ssr_pkg::out_item_t               out_o
);

  localparam int FillW  = $clog2(MaxPattern + 1);
  localparam int BurstW = ssr_pkg::NUM_REPL * ssr_pkg::BYTE_W;

  logic [ssr_pkg::CFG_DATA_W-1:0] pat_q, rep_q;
  logic [ssr_pkg::LEN_W-1:0]      plen_q, rlen_q;

  logic [ssr_pkg::BYTE_W-1:0] win_q [MaxPattern];
  logic [ssr_pkg::BYTE_W-1:0] win_d [MaxPattern];
  logic [ssr_pkg::BYTE_W-1:0] win_n [MaxPattern];
  logic [ssr_pkg::BYTE_W-1:0] win_s [MaxPattern];
  logic [FillW-1:0]           fill_q, fill_d, fill_c, fill_inc, plen_eff;
  logic [ssr_pkg::CNT_W-1:0]  rlen_eff, cnt_n;
  logic [BurstW-1:0]          burst_q, burst_d, burst_n;
  logic                       hit, full;
  ssr_pkg::out_item_t         out_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q  <= '0;
      plen_q <= ssr_pkg::LEN_W'(1);
      rep_q  <= '0;
      rlen_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ssr_pkg::REG_PATTERN_BYTES:     pat_q  <= cfg_data_i;
        ssr_pkg::REG_PATTERN_LEN:       plen_q <= cfg_data_i[ssr_pkg::LEN_W-1:0];
        ssr_pkg::REG_REPLACEMENT_BYTES: rep_q  <= cfg_data_i;
        ssr_pkg::REG_REPLACEMENT_LEN:   rlen_q <= cfg_data_i[ssr_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // effective lengths: pattern 1..MaxPattern, replacement 0..8
  always_comb begin
    if (plen_q == '0) begin
      plen_eff = FillW'(1);
    end else if (plen_q > ssr_pkg::LEN_W'(MaxPattern)) begin
      plen_eff = FillW'(MaxPattern);
    end else begin
      plen_eff = FillW'(plen_q);
    end
    if (rlen_q > ssr_pkg::CNT_W'(ssr_pkg::NUM_REPL)) begin
      rlen_eff = ssr_pkg::CNT_W'(ssr_pkg::NUM_REPL);
    end else begin
      rlen_eff = ssr_pkg::CNT_W'(rlen_q);
    end
  end

  // window with the new byte appended, its shifted form and the compare
  always_comb begin
    fill_c   = (fill_q >= plen_eff) ? '0 : fill_q;
    fill_inc = fill_c + FillW'(1);
    full     = (fill_inc >= plen_eff);
    hit      = 1'b1;
    for (int i = 0; i < MaxPattern; i++) begin
      win_n[i] = (FillW'(i) == fill_c) ? in_i.data_byte : win_q[i];
    end
    for (int i = 0; i < MaxPattern; i++) begin
      win_s[i] = (i < MaxPattern - 1) ? win_n[(i + 1) % MaxPattern] : win_n[i];
      if (FillW'(i) < plen_eff &&
          win_n[i] != pat_q[i*ssr_pkg::BYTE_W +: ssr_pkg::BYTE_W]) begin
        hit = 1'b0;
      end
    end
  end

  // burst the presented word would produce
  always_comb begin
    burst_n = '0;
    cnt_n   = '0;
    if (in_i.cmd == ssr_pkg::CMD_EOL) begin
      burst_n = {ssr_pkg::NUM_REPL{ssr_pkg::NEWLINE}};
      for (int i = 0; i < MaxPattern; i++) begin
        if (FillW'(i) < fill_c) begin
          burst_n[i*ssr_pkg::BYTE_W +: ssr_pkg::BYTE_W] = win_q[i];
        end
      end
      cnt_n = ssr_pkg::CNT_W'(fill_c) + ssr_pkg::CNT_W'(1);
    end else if (full && hit) begin
      burst_n = rep_q;
      cnt_n   = rlen_eff;
    end else if (full) begin
      burst_n[ssr_pkg::BYTE_W-1:0] = win_n[0];
      cnt_n   = ssr_pkg::CNT_W'(1);
    end
  end

  assign stat_o.burst_cnt = cnt_n;

  // window and fill update
  always_comb begin
    win_d  = win_q;
    fill_d = fill_q;
    if (cfg_we_i && cfg_index_i == ssr_pkg::REG_PATTERN_LEN) begin
      fill_d = '0;
    end
    if (cmd_i.take) begin
      if (in_i.cmd == ssr_pkg::CMD_EOL) begin
        fill_d = '0;
      end else if (!full) begin
        win_d  = win_n;
        fill_d = fill_inc;
      end else if (hit) begin
        win_d  = win_n;
        fill_d = '0;
      end else begin
        win_d  = win_s;
        fill_d = fill_c;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  // burst buffer: loaded on accept, drained a byte at a time
  always_comb begin
    burst_d = burst_q;
    if (cmd_i.take) begin
      burst_d = burst_n;
    end else if (cmd_i.emit) begin
      burst_d = burst_q >> ssr_pkg::BYTE_W;
    end
  end

  always_ff @(posedge clk_i) begin
    burst_q <= burst_d;
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.out_byte    <= burst_q[ssr_pkg::BYTE_W-1:0];
      out_q.last_of_run <= cmd_i.last;
    end
  end

  assign out_o = out_q;

endmodule

>>> hw/rtl/ssr_ctrl.sv
// ssr_ctrl: controller of the search and replace block: accept and emit
// sequencing, burst counter and output valid; uses ssr_pkg and the assert macros
`include "stream_search_replace_assert.svh"

module ssr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  ssr_pkg::dp_stat_t   stat_i,
  output ssr_pkg::ctrl_cmd_t  cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic                      state_q, state_d;
  logic [ssr_pkg::CNT_W-1:0] remain_q, remain_d;
  logic                      out_valid_q, out_valid_d;
  logic                      out_free, emit, final_byte, take;

  // handshake decisions
  always_comb begin
    out_free   = !out_valid_q || out_ready_i;
    emit       = (state_q == ST_EMIT) && out_free;
    final_byte = emit && (remain_q == ssr_pkg::CNT_W'(1));
    in_ready_o = (state_q == ST_IDLE) || final_byte;
    take       = in_valid_i && in_ready_o;
  end

  assign cmd_o.take = take;
  assign cmd_o.emit = emit;
  assign cmd_o.last = final_byte;

  // next state and burst counter
  always_comb begin
    state_d  = state_q;
    remain_d = remain_q;
    if (take) begin
      if (stat_i.burst_cnt != '0) begin
        state_d  = ST_EMIT;
        remain_d = stat_i.burst_cnt;
      end else begin
        state_d  = ST_IDLE;
        remain_d = '0;
      end
    end else if (final_byte) begin
      state_d  = ST_IDLE;
      remain_d = '0;
    end else if (emit) begin
      remain_d = remain_q - ssr_pkg::CNT_W'(1);
    end
  end

  // output valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      remain_q    <= remain_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // checks
  `SSR_ASSERT(a_emit_has_count, (state_q == ST_EMIT) |-> (remain_q != '0), "emit state with empty burst")
  `SSR_ASSERT(a_burst_bound, stat_i.burst_cnt <= ssr_pkg::CNT_W'(8), "burst longer than eight words")
  `SSR_ASSERT(a_burst_start, (take && stat_i.burst_cnt != '0) |=> (state_q == ST_EMIT && remain_q == $past(stat_i.burst_cnt)), "burst not started")
  `SSR_ASSERT(a_count_down, (emit && !take && remain_q > ssr_pkg::CNT_W'(1)) |=> (remain_q == $past(remain_q) - ssr_pkg::CNT_W'(1)), "burst count skipped")
  `SSR_ASSERT(a_emit_fills_out, emit |=> out_valid_q, "emitted word not shown")

endmodule

>>> hw/rtl/stream_search_replace.sv
// stream_search_replace: top level of the streaming search and replace block
// depends on ssr_pkg, ssr_ctrl and ssr_dp
//
// Usage:
//   Input channel (in_valid_i/in_ready_o, in_i): one word per text byte, cmd 0
//   with data_byte, or cmd 1 closing a line. Output channel (out_valid_o,
//   out_ready_i, out_o): result words, out_byte plus last_of_run on the final
//   word caused by one input word. Config channel (cfg_valid_i, cfg_index_i,
//   cfg_data_i) is always ready; write it only while the block is idle.
//   Index 0 pattern bytes, 1 pattern length (clears the held window),
//   2 replacement bytes, 3 replacement length.
// Flow:
//   A word that produces no result leaves the controller idle. A word producing n
//   results loads the burst buffer on acceptance; the bytes then move into the
//   output register one result per cycle while the receiver is ready, and the
//   next input word is taken in the cycle the last of them enters the output
//   register. The single output register, fed one byte per cycle from the burst
//   buffer, paces the results.
// Reset: configuration returns to pattern length 1, empty replacement, zero
//   bytes; the window is empty and no result is pending.
// Stall: a held output word stays put, the burst waits and no new input word
//   is taken until the burst has drained into the output register.
module stream_search_replace #(
  parameter int MAX_PATTERN = ssr_pkg::MAX_PATTERN_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  ssr_pkg::in_item_t              in_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output ssr_pkg::out_item_t             out_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ssr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ssr_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  ssr_pkg::ctrl_cmd_t cmd;
  ssr_pkg::dp_stat_t  stat;

  // config writes are taken at once
  assign cfg_ready_o = 1'b1;

  // sequencing
  ssr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // window, compare and output data
  ssr_dp #(
    .MaxPattern (MAX_PATTERN)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (in_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_o       (out_o)
  );

endmodule
